// ===== rtl/cas_pkg.sv =====
`default_nettype none
package cas_pkg;

    localparam logic [7:0] KEY_FIRST    = 8'd69;
    localparam logic [7:0] KEY_SECOND   = 8'd82;
    localparam logic [7:0] IDENT_LEVEL  = 8'hFF;
    localparam logic [7:0] TRIGGER_MODE = 8'd2;
    localparam logic [5:0] RESTART_COUNT = 6'd6;
    localparam logic [5:0] FLUSH_COUNT   = 6'd3;
    localparam logic [5:0] PULSE_CAP     = 6'd32;
    localparam logic [7:0] MAX_AVERAGE   = 8'd15;

    localparam int OPQ_DEPTH = 4;
    localparam int OPQ_PTR_W = $clog2(OPQ_DEPTH);
    localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_CMD,
        KIND_CAPTURE,
        KIND_PULSE,
        KIND_UNUSED
    } t_kind;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_TRIGGER,
        OP_COLLECT,
        OP_CAPTURE,
        OP_PULSE
    } t_op_kind;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SINGLE,
        ACT_OVERWRITE,
        ACT_ADD,
        ACT_AVERAGE
    } t_action;

    typedef struct packed {
        t_op_kind    kind;
        logic        ident;
        logic [15:0] delay;
        logic [7:0]  level;
        logic [7:0]  mode;
        logic [3:0]  average;
    } t_op;

    typedef struct packed {
        logic valid;
        t_op  op;
    } t_op_beat;

    typedef struct packed {
        logic        command_accepted;
        logic        exposure_change;
        logic        send_ident;
        t_action     data_action;
        logic        converter_running;
        logic        sensor_flushed;
        logic [7:0]  collect_mode;
        logic [15:0] delay_value;
        logic [7:0]  level_value;
    } t_result;

endpackage
`default_nettype wire

// ===== rtl/cas_front.sv =====
`default_nettype none
module cas_front import cas_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_key_first,
    input  wire logic [7:0]  i_key_second,
    input  wire logic [15:0] i_cmd_delay,
    input  wire logic [7:0]  i_cmd_level,
    input  wire logic [7:0]  i_cmd_mode,
    input  wire logic [7:0]  i_cmd_average,
    output t_op_beat         o_op,
    input  wire logic        i_take
);

    t_op                  r_queue [OPQ_DEPTH];
    logic [OPQ_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [OPQ_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [OPQ_CNT_W-1:0] r_count,  n_count;
    t_op                  w_op;
    logic                 w_push_ok;
    logic                 w_take_ok;
    logic                 w_key_ok;

    // classify the incoming beat
    always_comb begin
        w_op         = '0;
        w_op.kind    = OP_NONE;
        w_op.ident   = (i_cmd_level == IDENT_LEVEL);
        w_op.delay   = i_cmd_delay;
        w_op.level   = i_cmd_level;
        w_op.mode    = i_cmd_mode;
        w_op.average = ((i_cmd_average != 8'd0) && (i_cmd_average <= MAX_AVERAGE))
                       ? i_cmd_average[3:0] : 4'd1;
        w_key_ok     = (i_key_first == KEY_FIRST) && (i_key_second == KEY_SECOND);
        case (t_kind'(i_kind))
            KIND_CMD: begin
                if (w_key_ok) begin
                    w_op.kind = (i_cmd_mode == TRIGGER_MODE) ? OP_TRIGGER : OP_COLLECT;
                end
            end
            KIND_CAPTURE: w_op.kind = OP_CAPTURE;
            KIND_PULSE:   w_op.kind = OP_PULSE;
            default:      w_op.kind = OP_NONE;
        endcase
    end

    assign full      = (r_count == OPQ_CNT_W'(OPQ_DEPTH));
    assign w_push_ok = push && !full;
    assign w_take_ok = i_take && (r_count != '0);

    always_comb begin
        n_wr_ptr = r_wr_ptr + OPQ_PTR_W'(w_push_ok);
        n_rd_ptr = r_rd_ptr + OPQ_PTR_W'(w_take_ok);
        n_count  = r_count + OPQ_CNT_W'(w_push_ok) - OPQ_CNT_W'(w_take_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_queue[r_wr_ptr] <= w_op;
        end
    end

    assign o_op.valid = (r_count != '0);
    assign o_op.op    = r_queue[r_rd_ptr];

endmodule
`default_nettype wire

// ===== rtl/cas_back.sv =====
`default_nettype none
module cas_back import cas_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  t_op_beat   i_op,
    output logic       o_take,
    output logic       empty,
    input  wire logic  pop,
    output t_result    o_res
);

    logic [5:0]  r_pulse_count, n_pulse_count;
    logic [3:0]  r_average,     n_average;
    logic [3:0]  r_remaining,   n_remaining;
    logic        r_flushed,     n_flushed;
    logic        r_running,     n_running;
    logic [7:0]  r_mode,        n_mode;
    logic [15:0] r_delay,       n_delay;
    logic [7:0]  r_level,       n_level;

    t_result     r_res [2];
    logic        r_res_wr, r_res_rd;
    logic [1:0]  r_res_cnt;
    t_result     w_res;
    logic        w_pop_ok;
    logic        w_exec;
    logic [6:0]  w_pulse_inc;

    assign empty    = (r_res_cnt == 2'd0);
    assign w_pop_ok = pop && !empty;
    assign o_take   = (r_res_cnt != 2'd2) || pop;
    assign w_exec   = o_take && i_op.valid;
    assign w_pulse_inc = {1'b0, r_pulse_count} + 7'd1;

    always_comb begin
        n_pulse_count = r_pulse_count;
        n_average     = r_average;
        n_remaining   = r_remaining;
        n_flushed     = r_flushed;
        n_running     = r_running;
        n_mode        = r_mode;
        n_delay       = r_delay;
        n_level       = r_level;
        w_res         = '0;
        w_res.data_action = ACT_NONE;
        case (i_op.op.kind)
            OP_TRIGGER: begin
                w_res.command_accepted = 1'b1;
                n_delay = i_op.op.delay;
                if (i_op.op.ident) begin
                    w_res.send_ident = 1'b1;
                end else begin
                    n_level = i_op.op.level;
                end
            end
            OP_COLLECT: begin
                w_res.command_accepted = 1'b1;
                w_res.exposure_change  = 1'b1;
                n_mode      = i_op.op.mode;
                n_average   = i_op.op.average;
                n_remaining = i_op.op.average;
            end
            OP_CAPTURE: begin
                n_running = 1'b0;
                if (r_average <= 4'd1) begin
                    w_res.data_action = ACT_SINGLE;
                end else begin
                    if (r_remaining == r_average) begin
                        n_pulse_count     = RESTART_COUNT;
                        w_res.data_action = ACT_OVERWRITE;
                    end else if ((r_remaining < r_average) && (r_remaining > 4'd1)) begin
                        n_pulse_count     = RESTART_COUNT;
                        w_res.data_action = ACT_ADD;
                    end else if (r_remaining == 4'd1) begin
                        w_res.data_action = ACT_AVERAGE;
                    end
                    if (r_remaining != 4'd0) begin
                        n_remaining = r_remaining - 4'd1;
                    end
                end
            end
            OP_PULSE: begin
                if (r_pulse_count == RESTART_COUNT) begin
                    n_running = 1'b1;
                end else if (r_pulse_count == FLUSH_COUNT) begin
                    n_flushed = 1'b1;
                end
                n_pulse_count = (w_pulse_inc > {1'b0, PULSE_CAP}) ? PULSE_CAP
                                                                  : w_pulse_inc[5:0];
            end
            default: begin
            end
        endcase
        w_res.converter_running = n_running;
        w_res.sensor_flushed    = n_flushed;
        w_res.collect_mode      = n_mode;
        w_res.delay_value       = n_delay;
        w_res.level_value       = n_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pulse_count <= '0;
            r_average     <= 4'd1;
            r_remaining   <= '0;
            r_flushed     <= 1'b0;
            r_running     <= 1'b0;
            r_mode        <= '0;
            r_delay       <= '0;
            r_level       <= '0;
            r_res_wr      <= 1'b0;
            r_res_rd      <= 1'b0;
            r_res_cnt     <= '0;
        end else begin
            if (w_exec) begin
                r_pulse_count <= n_pulse_count;
                r_average     <= n_average;
                r_remaining   <= n_remaining;
                r_flushed     <= n_flushed;
                r_running     <= n_running;
                r_mode        <= n_mode;
                r_delay       <= n_delay;
                r_level       <= n_level;
            end
            r_res_wr  <= r_res_wr ^ w_exec;
            r_res_rd  <= r_res_rd ^ w_pop_ok;
            r_res_cnt <= r_res_cnt + 2'(w_exec) - 2'(w_pop_ok);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_exec) begin
            r_res[r_res_wr] <= w_res;
        end
    end

    assign o_res = r_res[r_res_rd];

endmodule
`default_nettype wire

// ===== rtl/ccd_acquisition_sequencer.sv =====
// a pushed beat is registered in the op queue, then its result in the result queue, before it can be popped
// throughput: one beat per cycle on both sides while pop keeps pace; full or a held result stalls the flow
// a four-entry op queue separates the classify front from the execute back
// a two-entry result queue lets the back keep running while a result waits
// reset: synchronous active-low i_rst_n empties both queues and restores state
`default_nettype none
module ccd_acquisition_sequencer import cas_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [1:0]  i_kind,
    input  wire logic [7:0]  i_key_first,
    input  wire logic [7:0]  i_key_second,
    input  wire logic [15:0] i_cmd_delay,
    input  wire logic [7:0]  i_cmd_level,
    input  wire logic [7:0]  i_cmd_mode,
    input  wire logic [7:0]  i_cmd_average,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_command_accepted,
    output logic             o_exposure_change,
    output logic             o_send_ident,
    output logic [2:0]       o_data_action,
    output logic             o_converter_running,
    output logic             o_sensor_flushed,
    output logic [7:0]       o_collect_mode_out,
    output logic [15:0]      o_trigger_delay_out,
    output logic [7:0]       o_trigger_level_out
);

    t_op_beat w_op;
    logic     w_take;
    t_result  w_res;

    cas_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_kind        (i_kind),
        .i_key_first   (i_key_first),
        .i_key_second  (i_key_second),
        .i_cmd_delay   (i_cmd_delay),
        .i_cmd_level   (i_cmd_level),
        .i_cmd_mode    (i_cmd_mode),
        .i_cmd_average (i_cmd_average),
        .o_op          (w_op),
        .i_take        (w_take)
    );

    cas_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (w_op),
        .o_take  (w_take),
        .empty   (empty),
        .pop     (pop),
        .o_res   (w_res)
    );

    assign o_command_accepted  = w_res.command_accepted;
    assign o_exposure_change   = w_res.exposure_change;
    assign o_send_ident        = w_res.send_ident;
    assign o_data_action       = w_res.data_action;
    assign o_converter_running = w_res.converter_running;
    assign o_sensor_flushed    = w_res.sensor_flushed;
    assign o_collect_mode_out  = w_res.collect_mode;
    assign o_trigger_delay_out = w_res.delay_value;
    assign o_trigger_level_out = w_res.level_value;

    a_push_reaches_queue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full |=> w_op.valid)
        else $error("accepted beat missing from op queue");

    a_exec_fills_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_op.valid && w_take |=> !empty)
        else $error("executed op produced no result");

    a_expo_needs_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && (o_exposure_change || o_send_ident) |-> o_command_accepted)
        else $error("command flag without accepted command");

    a_cmd_no_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && o_command_accepted |-> (o_data_action == ACT_NONE))
        else $error("command beat carries a data action");

endmodule
`default_nettype wire
